// File: design/sgc_pkg.sv
// ----------------------------------------------------------------------------
// sgc_pkg
// Shared constants and elaboration-time table builders for the sRGB
// gray converter: linear-light decode table and midpoint thresholds.
// ----------------------------------------------------------------------------
`default_nettype none
package sgc_pkg;

  localparam int unsigned LinearFracBitsDef = 16;
  localparam int unsigned ChanW = 8;
  localparam int unsigned WRed = 19595;
  localparam int unsigned WGreen = 38470;
  localparam int unsigned WBlue = 7471;
  localparam int unsigned WeightW = 16;

  typedef logic [31:0] lin_rom_t [256];
  typedef logic [31:0] thr_rom_t [255];

  localparam logic [63:0] OneQ31 = 64'h8000_0000;

  // Q1.31 product, rounded
  function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
    return (a * b + (OneQ31 >> 1)) >> 31;
  endfunction

  function automatic logic [63:0] fifth_power(input logic [63:0] y);
    logic [63:0] y2;
    logic [63:0] y4;
    y2 = qmul(y, y);
    y4 = qmul(y2, y2);
    return qmul(y4, y);
  endfunction

  // power segment: t^2.4 as (t^2) * (t^2)^(1/5)
  function automatic logic [63:0] decode_pow(input logic [63:0] t_in);
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] r;
    logic [63:0] cand;
    t = (t_in > OneQ31) ? OneQ31 : t_in;
    s = qmul(t, t);
    r = '0;
    for (int bit_i = 31; bit_i >= 0; bit_i--) begin
      cand = r | (64'd1 << bit_i);
      if (cand <= OneQ31 && fifth_power(cand) <= s) r = cand;
    end
    return qmul(s, r);
  endfunction

  // decode of num/255
  function automatic logic [63:0] decode_255(input logic [63:0] num);
    if (num * 100000 < 64'd1031475) begin
      return (((num * 100) << 31) + 64'd164730) / 64'd329460;
    end
    return decode_pow((((num * 1000 + 64'd14025) << 31) + 64'd134512) / 64'd269025);
  endfunction

  // decode of num/510
  function automatic logic [63:0] decode_510(input logic [63:0] num);
    if (num * 100000 < 64'd2062950) begin
      return (((num * 100) << 31) + 64'd329460) / 64'd658920;
    end
    return decode_pow((((num * 1000 + 64'd28050) << 31) + 64'd269025) / 64'd538050);
  endfunction

  // linear table, rounded to nearest at fb fraction bits
  function automatic lin_rom_t build_lin(input int unsigned fb);
    lin_rom_t rom;
    logic [63:0] d;
    int unsigned drop;
    drop = 31 - fb;
    for (int k = 0; k < 256; k++) begin
      d = decode_255(64'(k));
      rom[k] = 32'((d + (64'd1 << (drop - 1))) >> drop);
    end
    return rom;
  endfunction

  // midpoint thresholds, rounded up at fb fraction bits
  function automatic thr_rom_t build_thr(input int unsigned fb);
    thr_rom_t rom;
    logic [63:0] d;
    int unsigned drop;
    drop = 31 - fb;
    for (int k = 0; k < 255; k++) begin
      d = decode_510(64'(2 * k + 1));
      rom[k] = 32'((d + (64'd1 << drop) - 64'd1) >> drop);
    end
    return rom;
  endfunction

endpackage
`default_nettype wire

// File: design/sgc_search.sv
// ----------------------------------------------------------------------------
// sgc_search
// Registered slice of the threshold binary search: resolves four level
// bits, starting at bit StepHi, against the midpoint threshold table.
// ----------------------------------------------------------------------------
`default_nettype none
module sgc_search #(
  parameter int unsigned LinearFracBits = sgc_pkg::LinearFracBitsDef,
  parameter int unsigned StepHi = 7
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      en_i,
  input  wire logic                      valid_i,
  input  wire logic [LinearFracBits+1:0] sum_i,
  input  wire logic [sgc_pkg::ChanW-1:0] level_i,
  output logic                           valid_o,
  output logic [LinearFracBits+1:0]      sum_o,
  output logic [sgc_pkg::ChanW-1:0]      level_o
);
  import sgc_pkg::*;

  localparam int unsigned LinW = LinearFracBits + 1;
  localparam thr_rom_t ThrRom = build_thr(LinearFracBits);

  logic [ChanW-1:0] level_d;
  logic [ChanW-1:0] level_q;
  logic [LinW:0]    sum_q;
  logic             valid_q;

  // four dependent steps: keep candidate if sum reaches its threshold
  always_comb begin
    logic [ChanW-1:0] cand;
    logic [ChanW-1:0] idx;
    level_d = level_i;
    for (int s = 0; s < 4; s++) begin
      cand = level_d | (ChanW'(1) << (StepHi - s));
      idx = cand - ChanW'(1);
      if (sum_i >= {1'b0, ThrRom[idx][LinW-1:0]}) level_d = cand;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      level_q <= level_d;
      sum_q   <= sum_i;
    end
  end

  assign valid_o = valid_q;
  assign sum_o   = sum_q;
  assign level_o = level_q;

endmodule
`default_nettype wire

// File: design/srgb_gamma_correct_grayscale_core.sv
// ----------------------------------------------------------------------------
// srgb_gamma_correct_grayscale_core
// sRGB pixel to gamma-correct gray: table decode to linear light, Rec.601
// weighting, and re-encode by search over midpoint thresholds.
// ----------------------------------------------------------------------------
//  channel | signals                          | direction
//  pixel   | valid_i, stall_o, red/green/blue | in
//  gray    | valid_o, stall_i, gray_o         | out
//
// One pixel per cycle unless the output stalls; stages: decode lookup, multiply,
// sum and round, two search slices of four threshold compares each.
// Reset clears the stage valid bits only.
// A stall at the output freezes every stage; stall_o = valid_o & stall_i.
`default_nettype none
module srgb_gamma_correct_grayscale_core #(
  parameter int unsigned LinearFracBits = sgc_pkg::LinearFracBitsDef
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      valid_i,
  output logic                           stall_o,
  input  wire logic [sgc_pkg::ChanW-1:0] red_i,
  input  wire logic [sgc_pkg::ChanW-1:0] green_i,
  input  wire logic [sgc_pkg::ChanW-1:0] blue_i,
  output logic                           valid_o,
  input  wire logic                      stall_i,
  output logic [sgc_pkg::ChanW-1:0]      gray_o
);
  import sgc_pkg::*;

  localparam int unsigned LinW  = LinearFracBits + 1;
  localparam int unsigned ProdW = LinW + WeightW;
  localparam int unsigned AccW  = ProdW + 2;
  localparam lin_rom_t LinRom = build_lin(LinearFracBits);

  logic             en;
  logic [2:0]       valid_q;
  logic [LinW-1:0]  lin_q  [3];
  logic [ProdW-1:0] prod_q [3];
  logic [LinW:0]    sum_d;
  logic [LinW:0]    sum_q;
  logic [AccW-1:0]  acc;
  logic             mid_valid;
  logic [LinW:0]    mid_sum;
  logic [ChanW-1:0] mid_level;
  logic [LinW:0]    out_sum;

  assign en      = !(valid_o && stall_i);
  assign stall_o = !en;

  // weighted sum, rounded back to the linear fraction width
  assign acc   = AccW'(prod_q[0]) + AccW'(prod_q[1]) + AccW'(prod_q[2])
               + AccW'(32768);
  assign sum_d = (LinW+1)'(acc >> WeightW);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  // stages 1-3: decode, weight, sum
  always_ff @(posedge clk_i) begin
    if (en) begin
      lin_q[0]  <= LinRom[red_i][LinW-1:0];
      lin_q[1]  <= LinRom[green_i][LinW-1:0];
      lin_q[2]  <= LinRom[blue_i][LinW-1:0];
      prod_q[0] <= ProdW'(lin_q[0]) * ProdW'(WRed);
      prod_q[1] <= ProdW'(lin_q[1]) * ProdW'(WGreen);
      prod_q[2] <= ProdW'(lin_q[2]) * ProdW'(WBlue);
      sum_q     <= sum_d;
    end
  end

  // stages 4-5: threshold search, high then low level bits
  sgc_search #(.LinearFracBits(LinearFracBits), .StepHi(7)) u_search_hi (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(valid_q[2]), .sum_i(sum_q), .level_i('0),
    .valid_o(mid_valid), .sum_o(mid_sum), .level_o(mid_level)
  );

  sgc_search #(.LinearFracBits(LinearFracBits), .StepHi(3)) u_search_lo (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(mid_valid), .sum_i(mid_sum), .level_i(mid_level),
    .valid_o(valid_o), .sum_o(out_sum), .level_o(gray_o)
  );

  // the final sum is not used; it is only reduced into unused_sum
  logic unused_sum;
  assign unused_sum = ^out_sum;

  a_stall_def: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o == (valid_o && stall_i)) else $error("stall_o mismatch");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && stall_i) |=> (valid_o && $stable(gray_o)))
    else $error("stalled result changed");

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!(valid_o && stall_i)) |=> (mid_valid == $past(valid_q[2])))
    else $error("pipeline valid lost");

endmodule
`default_nettype wire
